// ===== sv/pbpp_pkg.sv =====
// shared definitions for the page buffer pool policy unit
// parameter defaults, request and status codes, scan status bundle
// no dependencies
package pbpp_pkg;

  localparam int unsigned PoolFramesDef = 16;
  localparam int unsigned PageBitsDef   = 32;
  localparam int unsigned PinBitsDef    = 16;
  localparam int unsigned AgeBits       = 64;

  typedef enum logic [2:0] {
    ACT_FETCH     = 3'd0,
    ACT_RELEASE   = 3'd1,
    ACT_FLUSH     = 3'd2,
    ACT_DELETE    = 3'd3,
    ACT_FLUSH_ALL = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALL_PINNED = 2'd1,
    ST_NOT_CACHED = 2'd2,
    ST_PINNED     = 2'd3
  } status_e;

  typedef struct packed {
    logic hit;
    logic victim;
  } scan_flags_t;

endpackage

// ===== sv/page_buffer_pool_policy_unit.sv =====
// top level of the page buffer pool policy unit: lru frames with pin counts
// holds the frame memory, the request sequencer and the result register
// depends on pbpp_pkg and pbpp_scan_unit
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o   | action, page_number, mark_dirty
//   out     | output    | out_valid_o / out_stall_i | status, was_hit, frame_index,
//           |           |                           | write_back, write_page, read_in,
//           |           |                           | free_page, last
//
// fetch, release, flush and delete scan every frame: the scan reads
// one frame per cycle from the single read port of the frame memory
// flush all walks the frames one per cycle, pausing on each written frame to load its result,
// which a stalled output can delay; reset clears valid and dirty bits at once, no clearing pass
// a stalled result delays only the next result; the next request is taken
// while the last result of the previous one is still waiting
module page_buffer_pool_policy_unit #(
  parameter int unsigned POOL_FRAMES = pbpp_pkg::PoolFramesDef,
  parameter int unsigned PAGE_BITS   = pbpp_pkg::PageBitsDef,
  parameter int unsigned PIN_BITS    = pbpp_pkg::PinBitsDef,
  localparam int unsigned IdxW       = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           action_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 mark_dirty_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic                 was_hit_o,
  output logic [IdxW-1:0]      frame_index_o,
  output logic                 write_back_o,
  output logic [PAGE_BITS-1:0] write_page_o,
  output logic                 read_in_o,
  output logic                 free_page_o,
  output logic                 last_o
);

  localparam int unsigned AgeW = pbpp_pkg::AgeBits;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_DECIDE  = 6'b001000,
    S_FA_SCAN = 6'b010000,
    S_FA_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [PIN_BITS-1:0]  pins;
    logic [AgeW-1:0]      age;
  } entry_t;

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        cnt_q, cnt_d;
  logic [2:0]             act_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic                   md_q;
  logic [POOL_FRAMES-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [AgeW-1:0]        clock_q, clock_d, clock_inc;
  logic                   chk_q;
  logic [IdxW-1:0]        chk_idx_q;

  entry_t                 mem_q [POOL_FRAMES];
  entry_t                 rd_q;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  entry_t                 wr_data;

  logic                   out_vld_q;
  logic [1:0]             status_q, o_status;
  logic                   hit_q, o_hit;
  logic [IdxW-1:0]        frame_q, o_frame;
  logic                   wb_q, o_wb;
  logic [PAGE_BITS-1:0]   wpage_q, o_wpage;
  logic                   rd_in_q, o_rd_in;
  logic                   free_q, o_free;
  logic                   last_q, o_last;
  logic                   out_ld, out_free;

  logic                   accept, scan_start;
  pbpp_pkg::scan_flags_t  flags;
  logic [IdxW-1:0]        hit_idx, vic_idx;
  logic [PIN_BITS-1:0]    hit_pins, pins_inc, pins_dec;
  logic [AgeW-1:0]        hit_age;
  logic [PAGE_BITS-1:0]   vic_page;
  logic [POOL_FRAMES-1:0] vd, cnt_oh;
  logic                   fa_last;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign scan_start = accept;

  assign vd        = valid_q & dirty_q;
  assign cnt_oh    = {{(POOL_FRAMES-1){1'b0}}, 1'b1} << cnt_q;
  assign fa_last   = ((vd & ~cnt_oh) == '0);
  assign clock_inc = clock_q + {{(AgeW-1){1'b0}}, 1'b1};
  assign pins_inc  = (hit_pins == '1) ? hit_pins : hit_pins + {{(PIN_BITS-1){1'b0}}, 1'b1};
  assign pins_dec  = (hit_pins != '0) ? hit_pins - {{(PIN_BITS-1){1'b0}}, 1'b1} : '0;

  pbpp_scan_unit #(
    .PAGE_BITS (PAGE_BITS),
    .PIN_BITS  (PIN_BITS),
    .IDX_W     (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .sample_i   (chk_q),
    .idx_i      (chk_idx_q),
    .valid_i    (valid_q[chk_idx_q]),
    .page_i     (rd_q.page),
    .pins_i     (rd_q.pins),
    .age_i      (rd_q.age),
    .key_i      (page_q),
    .flags_o    (flags),
    .hit_idx_o  (hit_idx),
    .hit_pins_o (hit_pins),
    .hit_age_o  (hit_age),
    .vic_idx_o  (vic_idx),
    .vic_page_o (vic_page)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    clock_d  = clock_q;
    wr_en    = 1'b0;
    wr_addr  = hit_idx;
    wr_data  = '0;
    out_ld   = 1'b0;
    o_status = pbpp_pkg::ST_OK;
    o_hit    = 1'b0;
    o_frame  = '0;
    o_wb     = 1'b0;
    o_wpage  = '0;
    o_rd_in  = 1'b0;
    o_free   = 1'b0;
    o_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          if (action_i == pbpp_pkg::ACT_FLUSH_ALL) begin
            state_d = (vd == '0) ? S_DECIDE : S_FA_SCAN;
          end else if (action_i > pbpp_pkg::ACT_FLUSH_ALL) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == IdxW'(POOL_FRAMES - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + {{(IdxW-1){1'b0}}, 1'b1};
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
          unique case (act_q)
            pbpp_pkg::ACT_FETCH: begin
              if (flags.hit) begin
                wr_en    = 1'b1;
                wr_addr  = hit_idx;
                wr_data  = '{page: page_q, pins: pins_inc, age: clock_inc};
                clock_d  = clock_inc;
                o_hit    = 1'b1;
                o_frame  = hit_idx;
              end else if (flags.victim) begin
                wr_en    = 1'b1;
                wr_addr  = vic_idx;
                wr_data  = '{page: page_q, pins: {{(PIN_BITS-1){1'b0}}, 1'b1},
                             age: clock_inc};
                clock_d  = clock_inc;
                o_wb     = valid_q[vic_idx] && dirty_q[vic_idx];
                o_wpage  = o_wb ? vic_page : '0;
                o_frame  = vic_idx;
                o_rd_in  = 1'b1;
                valid_d[vic_idx] = 1'b1;
                dirty_d[vic_idx] = 1'b0;
              end else begin
                o_status = pbpp_pkg::ST_ALL_PINNED;
              end
            end
            pbpp_pkg::ACT_RELEASE: begin
              if (flags.hit) begin
                wr_en   = 1'b1;
                wr_addr = hit_idx;
                wr_data = '{page: page_q, pins: pins_dec, age: hit_age};
                o_frame = hit_idx;
                dirty_d[hit_idx] = dirty_q[hit_idx] | md_q;
              end else begin
                o_status = pbpp_pkg::ST_NOT_CACHED;
              end
            end
            pbpp_pkg::ACT_FLUSH: begin
              if (flags.hit) begin
                o_frame = hit_idx;
                o_wb    = 1'b1;
                o_wpage = page_q;
                dirty_d[hit_idx] = 1'b0;
              end else begin
                o_status = pbpp_pkg::ST_NOT_CACHED;
              end
            end
            pbpp_pkg::ACT_DELETE: begin
              if (flags.hit && hit_pins != '0) begin
                o_status = pbpp_pkg::ST_PINNED;
                o_frame  = hit_idx;
              end else if (flags.hit) begin
                o_frame = hit_idx;
                o_free  = 1'b1;
                valid_d[hit_idx] = 1'b0;
                dirty_d[hit_idx] = 1'b0;
              end else begin
                o_free = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FA_SCAN: begin
        if (vd[cnt_q]) begin
          state_d = S_FA_OUT;
        end else begin
          cnt_d = cnt_q + {{(IdxW-1){1'b0}}, 1'b1};
        end
      end
      S_FA_OUT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          o_frame = cnt_q;
          o_wb    = 1'b1;
          o_wpage = rd_q.page;
          o_last  = fa_last;
          dirty_d[cnt_q] = 1'b0;
          if (fa_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_FA_SCAN;
            cnt_d   = cnt_q + {{(IdxW-1){1'b0}}, 1'b1};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      dirty_q   <= '0;
      clock_q   <= '0;
      chk_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      clock_q   <= clock_d;
      chk_q     <= (state_q == S_SCAN);
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q;
    if (accept) begin
      act_q  <= action_i;
      page_q <= page_number_i;
      md_q   <= mark_dirty_i;
    end
    if (out_ld) begin
      status_q <= o_status;
      hit_q    <= o_hit;
      frame_q  <= o_frame;
      wb_q     <= o_wb;
      wpage_q  <= o_wpage;
      rd_in_q  <= o_rd_in;
      free_q   <= o_free;
      last_q   <= o_last;
    end
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[cnt_q];
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign was_hit_o     = hit_q;
  assign frame_index_o = frame_q;
  assign write_back_o  = wb_q;
  assign write_page_o  = wpage_q;
  assign read_in_o     = rd_in_q;
  assign free_page_o   = free_q;
  assign last_o        = last_q;

endmodule

// ===== sv/pbpp_scan_unit.sv =====
// frame scan unit: page match, oldest unpinned frame, first unpinned frame
// looks at one frame per cycle, cleared at the start of each request
// depends on pbpp_pkg
module pbpp_scan_unit #(
  parameter int unsigned PAGE_BITS = pbpp_pkg::PageBitsDef,
  parameter int unsigned PIN_BITS  = pbpp_pkg::PinBitsDef,
  parameter int unsigned IDX_W     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       sample_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic                       valid_i,
  input  logic [PAGE_BITS-1:0]       page_i,
  input  logic [PIN_BITS-1:0]        pins_i,
  input  logic [pbpp_pkg::AgeBits-1:0] age_i,
  input  logic [PAGE_BITS-1:0]       key_i,
  output pbpp_pkg::scan_flags_t      flags_o,
  output logic [IDX_W-1:0]           hit_idx_o,
  output logic [PIN_BITS-1:0]        hit_pins_o,
  output logic [pbpp_pkg::AgeBits-1:0] hit_age_o,
  output logic [IDX_W-1:0]           vic_idx_o,
  output logic [PAGE_BITS-1:0]       vic_page_o
);

  logic                         hit_q, hit_d;
  logic                         best_q, best_d;
  logic                         fu_q, fu_d;
  logic [IDX_W-1:0]             hit_idx_q, best_idx_q, fu_idx_q;
  logic [PIN_BITS-1:0]          hit_pins_q;
  logic [pbpp_pkg::AgeBits-1:0] hit_age_q, best_age_q;
  logic [PAGE_BITS-1:0]         best_page_q, fu_page_q;
  logic                         match, unpinned, older;

  assign match    = valid_i && (page_i == key_i);
  assign unpinned = !valid_i || (pins_i == '0);
  assign older    = valid_i && (pins_i == '0) && (age_i < best_age_q);

  always_comb begin
    hit_d  = hit_q;
    best_d = best_q;
    fu_d   = fu_q;
    if (start_i) begin
      hit_d  = 1'b0;
      best_d = 1'b0;
      fu_d   = 1'b0;
    end else if (sample_i) begin
      hit_d  = hit_q || match;
      best_d = best_q || older;
      fu_d   = fu_q || unpinned;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      best_q <= 1'b0;
      fu_q   <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      best_q <= best_d;
      fu_q   <= fu_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_age_q <= '1;
    end else if (sample_i) begin
      if (match && !hit_q) begin
        hit_idx_q  <= idx_i;
        hit_pins_q <= pins_i;
        hit_age_q  <= age_i;
      end
      if (older) begin
        best_age_q  <= age_i;
        best_idx_q  <= idx_i;
        best_page_q <= page_i;
      end
      if (unpinned && !fu_q) begin
        fu_idx_q  <= idx_i;
        fu_page_q <= page_i;
      end
    end
  end

  assign flags_o.hit    = hit_q;
  assign flags_o.victim = best_q || fu_q;
  assign hit_idx_o      = hit_idx_q;
  assign hit_pins_o     = hit_pins_q;
  assign hit_age_o      = hit_age_q;
  assign vic_idx_o      = best_q ? best_idx_q : fu_idx_q;
  assign vic_page_o     = best_q ? best_page_q : fu_page_q;

endmodule

// ===== sv/pbpp_checker.sv =====
// port checker for the page buffer pool policy unit, bound to the top level
// depends on pbpp_pkg and page_buffer_pool_policy_unit
module pbpp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       was_hit_o,
  input logic       write_back_o,
  input logic       read_in_o,
  input logic       free_page_o,
  input logic       last_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a request transfer makes the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");

  // any error status ends the request and moves no data
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pbpp_pkg::ST_OK |->
      last_o && !write_back_o && !read_in_o && !free_page_o && !was_hit_o)
    else $error("error result with side effects");

  // a read-in belongs to a missed fetch only
  a_read_in_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_in_o |-> !was_hit_o && !free_page_o && last_o)
    else $error("read-in on a non-miss result");

  // a free comes from delete alone
  a_free_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && free_page_o |-> !write_back_o && !was_hit_o && last_o)
    else $error("free combined with other work");

endmodule

bind page_buffer_pool_policy_unit pbpp_checker u_pbpp_checker (.*);
